### rtl/core/single_wire_humidity_sensor_reader_macros.svh
// Assertion macros shared by the sensor reader RTL.
// Each macro carries its own label and ends with a semicolon.
`ifndef SINGLE_WIRE_HUMIDITY_SENSOR_READER_MACROS_SVH
`define SINGLE_WIRE_HUMIDITY_SENSOR_READER_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked on every rising clock edge outside reset
`define SWHS_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("swhs: same-cycle check failed");

// next-cycle implication
`define SWHS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("swhs: next-cycle check failed");

`else

`define SWHS_ASSERT_IMPLY(label, ante, cons)
`define SWHS_ASSERT_NEXT(label, ante, cons)

`endif

`endif

### rtl/core/swhs_pkg.sv
package swhs_pkg;

   // register map indexes (byte address = 4 * index)
   localparam logic [2:0] REG_START_LOW     = 3'd0;
   localparam logic [2:0] REG_RELEASE_HIGH  = 3'd1;
   localparam logic [2:0] REG_RESP_FIRST    = 3'd2;
   localparam logic [2:0] REG_RESP_SECOND   = 3'd3;
   localparam logic [2:0] REG_BIT_SAMPLE    = 3'd4;
   localparam logic [2:0] REG_BYTES_TO_READ = 3'd5;

   // register reset values
   localparam logic [14:0] START_LOW_RST     = 15'd18000;
   localparam logic [7:0]  RELEASE_HIGH_RST  = 8'd20;
   localparam logic [7:0]  RESP_FIRST_RST    = 8'd40;
   localparam logic [7:0]  RESP_SECOND_RST   = 8'd80;
   localparam logic [7:0]  BIT_SAMPLE_RST    = 8'd40;
   localparam logic [3:0]  BYTES_TO_READ_RST = 4'd5;

   // line drive codes
   localparam logic [1:0] LINE_RELEASED   = 2'd0;
   localparam logic [1:0] LINE_DRIVE_LOW  = 2'd1;
   localparam logic [1:0] LINE_DRIVE_HIGH = 2'd2;

   // response codes
   localparam logic [1:0] RESP_ABSENT = 2'd0;
   localparam logic [1:0] RESP_OK     = 2'd1;
   localparam logic [1:0] RESP_BAD    = 2'd2;

   typedef enum logic [3:0] {
      PH_IDLE      = 4'd0,
      PH_LOW       = 4'd1,
      PH_HIGH      = 4'd2,
      PH_RESP1     = 4'd3,
      PH_RESP2     = 4'd4,
      PH_RESP_LOW  = 4'd5,
      PH_BIT_HIGH  = 4'd6,
      PH_BIT_DELAY = 4'd7,
      PH_BIT_LOW   = 4'd8
   } phase_type;

   typedef struct packed {
      logic [14:0] start_low_ticks;
      logic [7:0]  release_high_ticks;
      logic [7:0]  response_first_sample_ticks;
      logic [7:0]  response_second_sample_ticks;
      logic [7:0]  bit_sample_ticks;
      logic [3:0]  bytes_to_read;
   } cfg_type;

   typedef struct packed {
      logic cmd;
      logic line_level;
   } req_type;

   typedef struct packed {
      logic [1:0] line_mode;
      logic       busy_res;
      logic       response_valid;
      logic [1:0] response_code;
      logic       byte_valid;
      logic [7:0] data_byte;
      logic       last_byte;
   } rsp_type;

endpackage

### rtl/core/swhs_csr.sv
module swhs_csr
   import swhs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output cfg_type     cfg
);

   cfg_type    cfg_ff, cfg_in;
   logic       wr_en;
   logic [2:0] reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_idx    = csr_paddr[4:2];
   assign cfg        = cfg_ff;

   // write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_START_LOW:     cfg_in.start_low_ticks              = csr_pwdata[14:0];
            REG_RELEASE_HIGH:  cfg_in.release_high_ticks           = csr_pwdata[7:0];
            REG_RESP_FIRST:    cfg_in.response_first_sample_ticks  = csr_pwdata[7:0];
            REG_RESP_SECOND:   cfg_in.response_second_sample_ticks = csr_pwdata[7:0];
            REG_BIT_SAMPLE:    cfg_in.bit_sample_ticks             = csr_pwdata[7:0];
            REG_BYTES_TO_READ: cfg_in.bytes_to_read                = csr_pwdata[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_low_ticks              <= START_LOW_RST;
         cfg_ff.release_high_ticks           <= RELEASE_HIGH_RST;
         cfg_ff.response_first_sample_ticks  <= RESP_FIRST_RST;
         cfg_ff.response_second_sample_ticks <= RESP_SECOND_RST;
         cfg_ff.bit_sample_ticks             <= BIT_SAMPLE_RST;
         cfg_ff.bytes_to_read                <= BYTES_TO_READ_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read mux
   always_comb begin
      case (reg_idx)
         REG_START_LOW:     csr_prdata = {17'd0, cfg_ff.start_low_ticks};
         REG_RELEASE_HIGH:  csr_prdata = {24'd0, cfg_ff.release_high_ticks};
         REG_RESP_FIRST:    csr_prdata = {24'd0, cfg_ff.response_first_sample_ticks};
         REG_RESP_SECOND:   csr_prdata = {24'd0, cfg_ff.response_second_sample_ticks};
         REG_BIT_SAMPLE:    csr_prdata = {24'd0, cfg_ff.bit_sample_ticks};
         REG_BYTES_TO_READ: csr_prdata = {28'd0, cfg_ff.bytes_to_read};
         default:           csr_prdata = 32'd0;
      endcase
   end

endmodule

### rtl/core/swhs_fsm.sv
module swhs_fsm
   import swhs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    step,
   input  req_type req,
   input  cfg_type cfg,
   output rsp_type rsp
);

   phase_type   phase_ff, phase_in;
   logic [14:0] tick_ff, tick_in;
   logic [2:0]  bit_idx_ff, bit_idx_in;
   logic [7:0]  shift_ff, shift_in;
   logic [3:0]  byte_cnt_ff, byte_cnt_in;
   logic [1:0]  resp_ff, resp_in;

   logic [14:0] limit;
   logic        timer_done;
   logic [3:0]  byte_cnt_inc;

   // phase timer limit for the timed phases
   always_comb begin
      case (phase_ff)
         PH_LOW:       limit = cfg.start_low_ticks;
         PH_HIGH:      limit = {7'd0, cfg.release_high_ticks};
         PH_RESP1:     limit = {7'd0, cfg.response_first_sample_ticks};
         PH_RESP2:     limit = {7'd0, cfg.response_second_sample_ticks};
         PH_BIT_DELAY: limit = {7'd0, cfg.bit_sample_ticks};
         default:      limit = 15'd0;
      endcase
   end

   assign timer_done   = (tick_ff >= limit);
   assign byte_cnt_inc = byte_cnt_ff + 4'd1;

   // next state and result for one tick
   always_comb begin
      phase_in    = phase_ff;
      tick_in     = tick_ff;
      bit_idx_in  = bit_idx_ff;
      shift_in    = shift_ff;
      byte_cnt_in = byte_cnt_ff;
      resp_in     = resp_ff;
      rsp         = '0;
      if (step) begin
         case (phase_ff)
            PH_IDLE: begin
               if (req.cmd) begin
                  phase_in = PH_LOW;
                  tick_in  = 15'd1;
               end
            end
            PH_LOW: begin
               if (timer_done) begin
                  phase_in = PH_HIGH;
                  tick_in  = 15'd1;
               end else begin
                  tick_in = tick_ff + 15'd1;
               end
            end
            PH_HIGH: begin
               if (timer_done) begin
                  phase_in = PH_RESP1;
                  tick_in  = 15'd1;
               end else begin
                  tick_in = tick_ff + 15'd1;
               end
            end
            PH_RESP1: begin
               if (!timer_done) begin
                  tick_in = tick_ff + 15'd1;
               end else if (!req.line_level) begin
                  phase_in = PH_RESP2;
                  tick_in  = 15'd1;
               end else begin
                  // nobody pulled the line low: sensor absent
                  resp_in            = RESP_ABSENT;
                  rsp.response_valid = 1'b1;
                  rsp.response_code  = RESP_ABSENT;
                  phase_in           = PH_RESP_LOW;
               end
            end
            PH_RESP2: begin
               if (timer_done) begin
                  resp_in            = req.line_level ? RESP_OK : RESP_BAD;
                  rsp.response_valid = 1'b1;
                  rsp.response_code  = req.line_level ? RESP_OK : RESP_BAD;
                  phase_in           = PH_RESP_LOW;
               end else begin
                  tick_in = tick_ff + 15'd1;
               end
            end
            PH_RESP_LOW: begin
               if (!req.line_level) begin
                  if (resp_ff == RESP_OK) begin
                     phase_in    = PH_BIT_HIGH;
                     bit_idx_in  = 3'd0;
                     shift_in    = 8'd0;
                     byte_cnt_in = 4'd0;
                  end else begin
                     phase_in = PH_IDLE;
                  end
               end
            end
            PH_BIT_HIGH: begin
               if (req.line_level) begin
                  phase_in = PH_BIT_DELAY;
                  tick_in  = 15'd1;
               end
            end
            PH_BIT_DELAY: begin
               if (timer_done) begin
                  shift_in   = {shift_ff[6:0], req.line_level};
                  bit_idx_in = bit_idx_ff + 3'd1;
                  phase_in   = PH_BIT_LOW;
               end else begin
                  tick_in = tick_ff + 15'd1;
               end
            end
            PH_BIT_LOW: begin
               if (!req.line_level) begin
                  if (bit_idx_ff == 3'd0) begin
                     // eighth bit done: hand out the byte
                     rsp.byte_valid = 1'b1;
                     rsp.data_byte  = shift_ff;
                     byte_cnt_in    = byte_cnt_inc;
                     if (byte_cnt_inc >= cfg.bytes_to_read) begin
                        rsp.last_byte = 1'b1;
                        phase_in      = PH_IDLE;
                     end else begin
                        shift_in = 8'd0;
                        phase_in = PH_BIT_HIGH;
                     end
                  end else begin
                     phase_in = PH_BIT_HIGH;
                  end
               end
            end
            default: phase_in = PH_IDLE;
         endcase
      end
      case (phase_in)
         PH_LOW:  rsp.line_mode = LINE_DRIVE_LOW;
         PH_HIGH: rsp.line_mode = LINE_DRIVE_HIGH;
         default: rsp.line_mode = LINE_RELEASED;
      endcase
      rsp.busy_res = (phase_in != PH_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         tick_ff     <= 15'd0;
         bit_idx_ff  <= 3'd0;
         shift_ff    <= 8'd0;
         byte_cnt_ff <= 4'd0;
         resp_ff     <= RESP_ABSENT;
      end else begin
         phase_ff    <= phase_in;
         tick_ff     <= tick_in;
         bit_idx_ff  <= bit_idx_in;
         shift_ff    <= shift_in;
         byte_cnt_ff <= byte_cnt_in;
         resp_ff     <= resp_in;
      end
   end

endmodule

### rtl/core/single_wire_humidity_sensor_reader.sv
// Single-wire humidity/temperature sensor master. Every req beat is one
// microsecond tick carrying the sampled data line level and an optional start
// request; every req beat yields exactly one rsp beat with the line drive to
// apply, the busy flag, and any response code or data byte decided on that
// tick. The block takes one beat per clock cycle while the result register is free
// or being drained by rsp_tready; a taken beat is held in the input register,
// then the protocol state machine and result register update together when the
// result slot is free. The user must write the timing registers over the APB
// port only while no transaction is running; the block does not enforce this.
`include "single_wire_humidity_sensor_reader_macros.svh"

module single_wire_humidity_sensor_reader
   import swhs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // req_tdata: [0] cmd, [1] line_level, [7:2] zero
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,
   // rsp_tdata: [1:0] line_mode, [2] busy_res, [3] response_valid,
   // [5:4] response_code, [6] byte_valid, [14:7] data_byte, [15] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cfg_type cfg;
   req_type in_ff, in_in;
   logic    in_valid_ff, in_valid_in;
   rsp_type rsp_ff, rsp_in, step_rsp;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    out_ready;
   logic    step;

   swhs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   swhs_fsm u_fsm (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .req   (in_ff),
      .cfg   (cfg),
      .rsp   (step_rsp)
   );

   // handshake: result slot frees when empty or being taken
   assign out_ready  = !rsp_valid_ff || rsp_tready;
   assign step       = in_valid_ff && out_ready;
   assign req_tready = !in_valid_ff || out_ready;

   // input register
   always_comb begin
      in_in       = in_ff;
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_in.cmd        = req_tdata[0];
         in_in.line_level = req_tdata[1];
         in_valid_in      = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
   end

   // result register
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (step) begin
         rsp_in       = step_rsp;
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_ff  <= in_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_ff.data_byte, rsp_ff.byte_valid, rsp_ff.response_code,
                        rsp_ff.response_valid, rsp_ff.busy_res, rsp_ff.line_mode};
   assign rsp_tlast  = rsp_ff.last_byte;

   `SWHS_ASSERT_NEXT(a_step_gives_result, step, rsp_valid_ff)
   `SWHS_ASSERT_NEXT(a_held_beat_kept, in_valid_ff && !step, in_valid_ff)
   `SWHS_ASSERT_IMPLY(a_one_event, rsp_valid_ff, !(rsp_ff.response_valid && rsp_ff.byte_valid))
   `SWHS_ASSERT_IMPLY(a_last_ends_run, rsp_valid_ff && rsp_ff.last_byte, rsp_ff.byte_valid && !rsp_ff.busy_res)
   `SWHS_ASSERT_IMPLY(a_drive_when_busy, rsp_valid_ff && (rsp_ff.line_mode != LINE_RELEASED), rsp_ff.busy_res)

endmodule
